@@ hw/rtl/hbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Height map sampler package
// Grid geometry, bank layout and the item types shared by all modules.
// ----------------------------------------------------------------------------
package hbs_pkg;

  localparam int GRID_SIDE   = 16;
  localparam int GRID_CELLS  = GRID_SIDE * GRID_SIDE;
  localparam int HALF_SIDE   = GRID_SIDE / 2;
  localparam int FRAC_BITS   = 8;
  localparam int FRAC_ONE    = 1 << FRAC_BITS;
  localparam int POS_LIMIT   = HALF_SIDE << FRAC_BITS;
  localparam int ROW_W       = (GRID_SIDE > 2) ? $clog2(GRID_SIDE) : 1;
  localparam int BANK_SIDE   = (GRID_SIDE + 1) / 2;
  localparam int BANK_DEPTH  = BANK_SIDE * BANK_SIDE;
  localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int NUM_BANKS   = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_WRITE = 1'b1
  } hbs_mode_e;

  typedef struct packed {
    hbs_mode_e          mode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_z;
    logic [7:0]         entry_index;
    logic [15:0]        entry_height;
  } hbs_cmd_t;

  typedef struct packed {
    logic [15:0] height;
    logic        in_range;
  } hbs_res_t;

  typedef struct packed {
    hbs_mode_e          op;
    logic               in_range;
    logic [1:0]         bank;
    logic [BANK_AW-1:0] addr;
    logic [15:0]        wdata;
    logic [7:0]         fx;
    logic [7:0]         fz;
  } hbs_entry_t;

endpackage

@@ hw/rtl/hbs_front.sv @@
// ----------------------------------------------------------------------------
// Height map sampler front end
// Classifies accepted commands and maps them onto the four cell banks.
// ----------------------------------------------------------------------------
module hbs_front import hbs_pkg::*; (
  input  logic       accept_i,
  input  hbs_cmd_t   cmd_i,
  output logic       push_o,
  output hbs_entry_t entry_o
);

  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] col;
  logic [7:0]       ix;
  logic [7:0]       iz;
  logic             on_map;
  logic             index_ok;

  always_comb begin
    row      = ROW_W'(cmd_i.entry_index / GRID_SIDE);
    col      = ROW_W'(cmd_i.entry_index % GRID_SIDE);
    ix       = cmd_i.pos_x[15:8];
    iz       = cmd_i.pos_z[15:8];
    on_map   = (int'(cmd_i.pos_x) >= 0) && (int'(cmd_i.pos_z) >= 0) &&
               (int'(cmd_i.pos_x) < POS_LIMIT) && (int'(cmd_i.pos_z) < POS_LIMIT);
    index_ok = int'(cmd_i.entry_index) < GRID_CELLS;

    entry_o.op       = cmd_i.mode;
    entry_o.wdata    = cmd_i.entry_height;
    entry_o.fx       = cmd_i.pos_x[7:0];
    entry_o.fz       = cmd_i.pos_z[7:0];
    entry_o.in_range = on_map;
    if (cmd_i.mode == OP_WRITE) begin
      entry_o.bank = {row[0], col[0]};
      entry_o.addr = BANK_AW'(int'(row >> 1) * BANK_SIDE + int'(col >> 1));
    end else begin
      entry_o.bank = 2'b00;
      entry_o.addr = BANK_AW'(int'(iz) * BANK_SIDE + int'(ix));
    end

    push_o = accept_i && ((cmd_i.mode == OP_QUERY) || index_ok);
  end

endmodule

@@ hw/rtl/hbs_queue.sv @@
// ----------------------------------------------------------------------------
// Height map sampler queue
// Short FIFO that decouples the front end from the bank datapath.
// ----------------------------------------------------------------------------
module hbs_queue import hbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  hbs_entry_t entry_i,
  input  logic       pop_i,
  output logic       full_o,
  output logic       valid_o,
  output hbs_entry_t entry_o
);

  hbs_entry_t        slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_pop;

  assign full_o  = count_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign entry_o = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ hw/rtl/hbs_back.sv @@
// ----------------------------------------------------------------------------
// Height map sampler back end
// Four cell banks by row and column parity, then a two-stage bilinear blend.
// ----------------------------------------------------------------------------
module hbs_back import hbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_i,
  input  hbs_entry_t entry_i,
  output logic       res_valid_o,
  output hbs_res_t   res_o
);

  logic [15:0] mem_q [NUM_BANKS][BANK_DEPTH];
  logic [15:0] rdata_q [NUM_BANKS];

  logic        s1_valid_q, s1_in_range_q;
  logic [7:0]  s1_fx_q, s1_fz_q;
  logic        s2_valid_q, s2_in_range_q;
  logic [7:0]  s2_fx_q;
  logic [23:0] h0_q, h0_d, h1_q, h1_d;
  logic        res_valid_q;
  hbs_res_t    res_q;

  logic [8:0]  wz, wx;
  logic [24:0] p00, p10, p01, p11;
  logic [32:0] blend;
  logic        pop_query;

  assign pop_query = pop_i && (entry_i.op == OP_QUERY);

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (pop_i && entry_i.op == OP_WRITE && entry_i.bank == 2'(b)) begin
        mem_q[b][entry_i.addr] <= entry_i.wdata;
      end
      if (pop_query && entry_i.in_range) begin
        rdata_q[b] <= mem_q[b][entry_i.addr];
      end
    end
  end

  always_comb begin
    wz    = 9'(FRAC_ONE) - {1'b0, s1_fz_q};
    p00   = wz * rdata_q[0];
    p10   = s1_fz_q * rdata_q[2];
    p01   = wz * rdata_q[1];
    p11   = s1_fz_q * rdata_q[3];
    h0_d  = 24'(p00 + p10);
    h1_d  = 24'(p01 + p11);
    wx    = 9'(FRAC_ONE) - {1'b0, s2_fx_q};
    blend = wx * h0_q + s2_fx_q * h1_q;
  end

  always_ff @(posedge clk_i) begin
    s1_in_range_q  <= entry_i.in_range;
    s1_fx_q        <= entry_i.fx;
    s1_fz_q        <= entry_i.fz;
    s2_in_range_q  <= s1_in_range_q;
    s2_fx_q        <= s1_fx_q;
    h0_q           <= h0_d;
    h1_q           <= h1_d;
    res_q.in_range <= s2_in_range_q;
    res_q.height   <= s2_in_range_q ? blend[31:16] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= pop_query;
      s2_valid_q  <= s1_valid_q;
      res_valid_q <= s2_valid_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_query_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_query |-> ##3 res_valid_o)
    else $error("query did not produce a result");

  a_write_gives_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && entry_i.op == OP_WRITE) |-> ##3 !res_valid_o)
    else $error("write produced a result");

  a_off_map_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.in_range) |-> (res_o.height == '0))
    else $error("off-map result carries a height");

endmodule

@@ hw/rtl/heightmap_bilinear_sampler.sv @@
// ----------------------------------------------------------------------------
// Height map bilinear sampler
// Grid of cell heights with write commands and bilinear height queries.
// ----------------------------------------------------------------------------
// The block takes one command per clock cycle whenever busy is low; a write
// stores one grid entry and produces nothing, a query produces exactly one
// result strobe after the queue, the bank read and the two blend stages, in
// command order. The grid is split into four banks by row and column parity,
// so the 2x2 cell block of a query is one read from each single-port bank in
// the same cycle; this sets the rate of one item per cycle. The back end
// drains the queue every cycle, so busy stays low in normal use and no
// result waits on the receiver. The banks are not cleared at reset: a query
// that touches an entry never written returns an undefined height.
module heightmap_bilinear_sampler import hbs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  hbs_cmd_t cmd_i,
  output logic     res_valid_o,
  output hbs_res_t res_o
);

  logic       accept;
  logic       push;
  logic       q_full;
  logic       q_valid;
  hbs_entry_t push_entry;
  hbs_entry_t pop_entry;

  assign busy   = q_full;
  assign accept = start && !q_full;

  hbs_front u_front (
    .accept_i (accept),
    .cmd_i    (cmd_i),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  hbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (q_valid),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (pop_entry)
  );

  hbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (q_valid),
    .entry_i     (pop_entry),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

@@ verif/heightmap_bilinear_sampler_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Height map bilinear sampler testbench
// Loads grid entries and issues height queries on and off the map, then
// compares every result strobe with a bilinear blend computed on the side.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler_tb;
  import hbs_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PRINT_LIMIT  = 50;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  hbs_cmd_t cmd_i  = '0;
  logic     res_valid_o;
  hbs_res_t res_o;

  logic [15:0] grid_heights [GRID_CELLS];
  bit          cell_written [GRID_CELLS];
  hbs_res_t    pending_heights [$];

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned queries_sent = 0;
  int unsigned writes_sent  = 0;
  int unsigned cycles       = 0;
  bit          gaps_on      = 1'b1;

  heightmap_bilinear_sampler u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic bit on_map(logic signed [15:0] px, logic signed [15:0] pz);
    int x;
    int z;
    x = px;
    z = pz;
    return (x >= 0) && (z >= 0) && (x < POS_LIMIT) && (z < POS_LIMIT);
  endfunction

  function automatic hbs_res_t bilinear_height(logic signed [15:0] px,
                                               logic signed [15:0] pz);
    hbs_res_t        r;
    int              x;
    int              z;
    int              col;
    int              row;
    longint unsigned fx;
    longint unsigned fz;
    longint unsigned h0;
    longint unsigned h1;
    longint unsigned h;
    r = '0;
    if (!on_map(px, pz)) return r;
    x   = px;
    z   = pz;
    col = (x >> FRAC_BITS) * 2;
    row = (z >> FRAC_BITS) * 2;
    fx  = x & (FRAC_ONE - 1);
    fz  = z & (FRAC_ONE - 1);
    h0  = (FRAC_ONE - fz) * grid_heights[row * GRID_SIDE + col]
        + fz * grid_heights[(row + 1) * GRID_SIDE + col];
    h1  = (FRAC_ONE - fz) * grid_heights[row * GRID_SIDE + col + 1]
        + fz * grid_heights[(row + 1) * GRID_SIDE + col + 1];
    h   = ((FRAC_ONE - fx) * h0 + fx * h1) >> (2 * FRAC_BITS);
    r.height   = 16'(h);
    r.in_range = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
  endtask

  task automatic send_cmd(input hbs_cmd_t c);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (c.mode == OP_WRITE) begin
      writes_sent++;
      if (c.entry_index < GRID_CELLS) begin
        grid_heights[c.entry_index] = c.entry_height;
        cell_written[c.entry_index] = 1'b1;
      end
    end else begin
      queries_sent++;
      pending_heights = {pending_heights, bilinear_height(c.pos_x, c.pos_z)};
    end
  endtask

  task automatic send_write(input logic [7:0] idx, input logic [15:0] value);
    hbs_cmd_t c;
    c.mode         = OP_WRITE;
    c.pos_x        = 16'($urandom);
    c.pos_z        = 16'($urandom);
    c.entry_index  = idx;
    c.entry_height = value;
    send_cmd(c);
  endtask

  // The four cells under an on-map position are loaded first, so that no
  // query ever reads an entry that was never written.
  task automatic send_query(input logic signed [15:0] px, input logic signed [15:0] pz);
    hbs_cmd_t c;
    int       idx;
    int       col;
    int       row;
    if (on_map(px, pz)) begin
      col = (int'(px) >> FRAC_BITS) * 2;
      row = (int'(pz) >> FRAC_BITS) * 2;
      for (int dr = 0; dr < 2; dr++) begin
        for (int dc = 0; dc < 2; dc++) begin
          idx = (row + dr) * GRID_SIDE + col + dc;
          if (!cell_written[idx]) send_write(8'(idx), 16'($urandom));
        end
      end
    end
    c.mode         = OP_QUERY;
    c.pos_x        = px;
    c.pos_z        = pz;
    c.entry_index  = 8'($urandom);
    c.entry_height = 16'($urandom);
    send_cmd(c);
  endtask

  task automatic test_corner_heights();
    send_write(8'd0, 16'hFFFF);
    send_write(8'd1, 16'hFFFF);
    send_write(8'd16, 16'hFFFF);
    send_write(8'd17, 16'hFFFF);
    send_query(16'sh0000, 16'sh0000);
    send_query(16'sh00FF, 16'sh00FF);
    send_write(8'd238, 16'h0000);
    send_write(8'd239, 16'hFFFF);
    send_write(8'd254, 16'h0000);
    send_write(8'd255, 16'h1234);
    send_query(16'sh0700, 16'sh0700);
    send_query(16'sh07FF, 16'sh07FF);
    send_query(16'sh0780, 16'sh0700);
  endtask

  task automatic test_off_map();
    send_query(-16'sd1, 16'sh0000);
    send_query(16'sh0000, -16'sd1);
    send_query(16'sh8000, 16'sh7FFF);
    send_query(16'(POS_LIMIT), 16'sh0000);
    send_query(16'sh0000, 16'(POS_LIMIT));
    send_query(16'sh7FFF, 16'sh7FFF);
  endtask

  task automatic test_ignored_fields();
    hbs_cmd_t c;
    c.mode         = OP_WRITE;
    c.pos_x        = 16'sh8000;
    c.pos_z        = 16'sh7FFF;
    c.entry_index  = 8'd17;
    c.entry_height = 16'hA5A5;
    send_cmd(c);
    c.mode         = OP_QUERY;
    c.pos_x        = 16'sh0080;
    c.pos_z        = 16'sh0080;
    c.entry_index  = 8'hFF;
    c.entry_height = 16'hFFFF;
    send_cmd(c);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned       pick;
    logic signed [15:0] px;
    logic signed [15:0] pz;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_query(16'($urandom_range(0, POS_LIMIT - 1)),
                   16'($urandom_range(0, POS_LIMIT - 1)));
      end else if (pick < 75) begin
        px = 16'($urandom_range(0, POS_LIMIT - 1));
        pz = 16'($urandom_range(0, POS_LIMIT - 1));
        if ($urandom_range(0, 1)) px = 16'(POS_LIMIT + $urandom_range(0, 255));
        else pz = 16'(-$urandom_range(1, 256));
        if ($urandom_range(0, 1)) send_query(px, pz);
        else send_query(pz, px);
      end else if (pick < 85) begin
        send_query(16'($urandom), 16'($urandom));
      end else begin
        send_write(8'($urandom), 16'($urandom));
      end
    end
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    hbs_res_t want;
    if (rst_ni && res_valid_o !== 1'b0) begin
      results_seen++;
      if (pending_heights.size() == 0) begin
        report_mismatch("unexpected result", 32'(res_o), 32'hx);
      end else begin
        want = pending_heights.pop_front();
        if (res_o.height !== want.height)
          report_mismatch("height", 32'(res_o.height), 32'(want.height));
        if (res_o.in_range !== want.in_range)
          report_mismatch("in_range", 32'(res_o.in_range), 32'(want.in_range));
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_heights();
    test_off_map();
    test_ignored_fields();
    test_random_traffic(240);
    test_random_traffic(160);
    gaps_on = 1'b0;
    test_random_traffic(100);
    start <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d queries and %0d grid writes, %0d of %0d cells loaded",
             queries_sent, writes_sent, cell_written.sum() with (int'(item)), GRID_CELLS);
    $display("checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
